// ===== rtl/bpr_pkg.sv =====
package bpr_pkg;

   localparam int unsigned PAT_BYTES = 16;

   typedef logic [7:0]  byte_type;
   typedef logic [4:0]  len_type;
   typedef logic [3:0]  bidx_type;
   typedef logic [15:0] cnt_type;
   typedef logic [63:0] csr_data_type;
   typedef logic [2:0]  csr_index_type;

   // register indexes of the configuration port
   localparam csr_index_type CSR_PATTERN_LOW      = 3'd0;
   localparam csr_index_type CSR_PATTERN_HIGH     = 3'd1;
   localparam csr_index_type CSR_REPLACEMENT_LOW  = 3'd2;
   localparam csr_index_type CSR_REPLACEMENT_HIGH = 3'd3;
   localparam csr_index_type CSR_PATTERN_LENGTH   = 3'd4;
   localparam csr_index_type CSR_REPLACE_LIMIT    = 3'd5;

   typedef struct packed {
      byte_type data_byte;
      logic     buffer_end;
   } bpr_req_type;

   typedef struct packed {
      byte_type out_byte;
      logic     was_replaced;
      logic     run_end;
      logic     buffer_done;
      cnt_type  replace_count;
   } bpr_rsp_type;

   // one input word's worth of results: window bytes first, then replacement bytes
   typedef struct packed {
      logic     last;
      len_type  win_cnt;
      bidx_type win_pos;
      len_type  rep_cnt;
      cnt_type  count;
   } bpr_run_type;

endpackage

// ===== rtl/bpr_cell.sv =====
module bpr_cell #(
   parameter int unsigned IDX = 0
) (
   input  logic              clock,
   input  logic              shift_en,
   input  bpr_pkg::byte_type shift_in,
   input  bpr_pkg::len_type  pat_len,
   input  bpr_pkg::byte_type pattern [bpr_pkg::PAT_BYTES],
   output bpr_pkg::byte_type q,
   output logic              hit
);

   localparam bpr_pkg::len_type POS = bpr_pkg::len_type'(IDX + 1);

   bpr_pkg::byte_type byte_ff;
   bpr_pkg::byte_type byte_in;
   bpr_pkg::len_type  sel;

   // cell IDX holds the byte IDX places behind the newest, so it lines up
   // with pattern byte pat_len-1-IDX; cells past the pattern always agree
   assign sel     = pat_len - POS;
   assign hit     = (pat_len < POS) || (shift_in == pattern[sel[3:0]]);
   assign byte_in = shift_en ? shift_in : byte_ff;
   assign q       = byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

// ===== rtl/bpr_window.sv =====
module bpr_window #(
   parameter int unsigned MAX_PATTERN = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  bpr_pkg::bpr_req_type req,
   input  bpr_pkg::len_type     pat_len,
   input  bpr_pkg::cnt_type     replace_limit,
   input  bpr_pkg::byte_type    pattern [bpr_pkg::PAT_BYTES],
   output logic                 run_valid,
   output bpr_pkg::bpr_run_type run,
   output bpr_pkg::byte_type    snap [MAX_PATTERN]
);

   localparam int unsigned FILL_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   bpr_pkg::byte_type chain [MAX_PATTERN];
   bpr_pkg::byte_type q     [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] hit;

   logic [FILL_W-1:0] fill_ff, fill_in;
   bpr_pkg::cnt_type  cnt_ff, cnt_in;

   bpr_pkg::len_type fill_p1;
   bpr_pkg::len_type keep;
   bpr_pkg::len_type win_cnt;
   bpr_pkg::len_type rep_cnt;
   bpr_pkg::cnt_type cnt_inc;
   logic             full;
   logic             allowed;
   logic             do_rep;

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      if (k == 0) begin : g_head
         assign chain[k] = req.data_byte;
      end else begin : g_link
         assign chain[k] = q[k-1];
      end
      bpr_cell #(.IDX(k)) u_cell (
         .clock    (clock),
         .shift_en (accept),
         .shift_in (chain[k]),
         .pat_len  (pat_len),
         .pattern  (pattern),
         .q        (q[k]),
         .hit      (hit[k])
      );
   end

   assign snap = chain;

   always_comb begin
      fill_p1 = bpr_pkg::len_type'(fill_ff) + 5'd1;
      full    = (pat_len != 5'd0) && (fill_p1 >= pat_len);
      allowed = (replace_limit == 16'd0) || (cnt_ff < replace_limit);
      do_rep  = full && (&hit) && allowed;
      cnt_inc = (do_rep && (cnt_ff != 16'hFFFF)) ? cnt_ff + 16'd1 : cnt_ff;

      // bytes left in the window when nothing is replaced
      if (pat_len == 5'd0) begin
         keep = 5'd0;
      end else if (full) begin
         keep = pat_len - 5'd1;
      end else begin
         keep = fill_p1;
      end

      rep_cnt = 5'd0;
      if (do_rep) begin
         win_cnt = fill_p1 - pat_len;
         rep_cnt = pat_len;
         keep    = 5'd0;
      end else if (req.buffer_end) begin
         // flush the whole window
         win_cnt = fill_p1;
         keep    = 5'd0;
      end else begin
         win_cnt = fill_p1 - keep;
      end

      run.last    = req.buffer_end;
      run.win_cnt = win_cnt;
      run.win_pos = bpr_pkg::bidx_type'(fill_p1 - 5'd1);
      run.rep_cnt = rep_cnt;
      run.count   = cnt_inc;
      run_valid   = accept && ((win_cnt != 5'd0) || do_rep);

      fill_in = accept ? keep[FILL_W-1:0] : fill_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         cnt_in = req.buffer_end ? 16'd0 : cnt_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// ===== rtl/bpr_drain.sv =====
module bpr_drain #(
   parameter int unsigned MAX_PATTERN = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 run_valid,
   input  bpr_pkg::bpr_run_type run,
   input  bpr_pkg::byte_type    snap [MAX_PATTERN],
   input  bpr_pkg::byte_type    replacement [bpr_pkg::PAT_BYTES],
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output bpr_pkg::bpr_rsp_type rsp_data,
   output logic                 pend_full
);

   localparam int unsigned IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic                 head_valid_ff, head_valid_in;
   bpr_pkg::bpr_run_type head_ff, head_in;
   bpr_pkg::byte_type    head_bytes_ff [MAX_PATTERN];
   bpr_pkg::byte_type    head_bytes_in [MAX_PATTERN];
   bpr_pkg::bidx_type    rep_idx_ff, rep_idx_in;

   logic                 pend_valid_ff, pend_valid_in;
   bpr_pkg::bpr_run_type pend_ff, pend_in;
   bpr_pkg::byte_type    pend_bytes_ff [MAX_PATTERN];
   bpr_pkg::byte_type    pend_bytes_in [MAX_PATTERN];

   logic       from_win;
   logic [5:0] remain;
   logic       run_end;
   logic       pop;
   logic       head_free;

   always_comb begin
      from_win  = head_ff.win_cnt != 5'd0;
      remain    = {1'b0, head_ff.win_cnt} + {1'b0, head_ff.rep_cnt};
      run_end   = remain == 6'd1;
      pop       = head_valid_ff && rsp_ready;
      head_free = !head_valid_ff || (pop && run_end);

      head_valid_in = head_valid_ff;
      head_in       = head_ff;
      head_bytes_in = head_bytes_ff;
      rep_idx_in    = rep_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      pend_bytes_in = pend_bytes_ff;

      if (head_free) begin
         rep_idx_in = 4'd0;
         if (pend_valid_ff) begin
            // advance the waiting run; the input side is stalled meanwhile
            head_valid_in = 1'b1;
            head_in       = pend_ff;
            head_bytes_in = pend_bytes_ff;
            pend_valid_in = run_valid;
            pend_in       = run;
            pend_bytes_in = snap;
         end else begin
            head_valid_in = run_valid;
            head_in       = run;
            head_bytes_in = snap;
         end
      end else begin
         if (pop) begin
            if (from_win) begin
               head_in.win_cnt = head_ff.win_cnt - 5'd1;
               head_in.win_pos = head_ff.win_pos - 4'd1;
            end else begin
               head_in.rep_cnt = head_ff.rep_cnt - 5'd1;
               rep_idx_in      = rep_idx_ff + 4'd1;
            end
         end
         if (run_valid) begin
            pend_valid_in = 1'b1;
            pend_in       = run;
            pend_bytes_in = snap;
         end
      end
   end

   always_comb begin
      rsp_valid              = head_valid_ff;
      rsp_data.out_byte      = from_win ? head_bytes_ff[head_ff.win_pos[IW-1:0]]
                                        : replacement[rep_idx_ff];
      rsp_data.was_replaced  = !from_win;
      rsp_data.run_end       = run_end;
      rsp_data.buffer_done   = run_end && head_ff.last;
      rsp_data.replace_count = head_ff.count;
      pend_full              = pend_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff       <= head_in;
      head_bytes_ff <= head_bytes_in;
      rep_idx_ff    <= rep_idx_in;
      pend_ff       <= pend_in;
      pend_bytes_ff <= pend_bytes_in;
   end

endmodule

// ===== rtl/byte_pattern_replace_core.sv =====
// The first result of an accepted word is registered into the head run, or into the waiting
//   run while the head is busy, before it shows on rsp. req takes one word per cycle unless
//   stalled; rsp moves one result per cycle while rsp_ready is high, one byte wide.
// The req side stalls only while one finished run waits behind the one being sent.
// Reset clears the configuration registers, window fill, replace count and run queue;
//   the window byte cells are not cleared.
module byte_pattern_replace_core #(
   parameter int unsigned MAX_PATTERN = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bpr_pkg::bpr_req_type     req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output bpr_pkg::bpr_rsp_type     rsp_data,
   input  logic                     csr_write_en,
   input  bpr_pkg::csr_index_type   csr_index,
   input  bpr_pkg::csr_data_type    csr_write_data
);

   bpr_pkg::csr_data_type pattern_low_ff;
   bpr_pkg::csr_data_type pattern_high_ff;
   bpr_pkg::csr_data_type replacement_low_ff;
   bpr_pkg::csr_data_type replacement_high_ff;
   bpr_pkg::len_type      pattern_length_ff;
   bpr_pkg::cnt_type      replace_limit_ff;

   bpr_pkg::byte_type    pattern     [bpr_pkg::PAT_BYTES];
   bpr_pkg::byte_type    replacement [bpr_pkg::PAT_BYTES];
   bpr_pkg::len_type     pat_len;
   logic                 accept;
   logic                 run_valid;
   bpr_pkg::bpr_run_type run;
   bpr_pkg::byte_type    snap [MAX_PATTERN];
   logic                 pend_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff      <= '0;
         pattern_high_ff     <= '0;
         replacement_low_ff  <= '0;
         replacement_high_ff <= '0;
         pattern_length_ff   <= '0;
         replace_limit_ff    <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            bpr_pkg::CSR_PATTERN_LOW:      pattern_low_ff      <= csr_write_data;
            bpr_pkg::CSR_PATTERN_HIGH:     pattern_high_ff     <= csr_write_data;
            bpr_pkg::CSR_REPLACEMENT_LOW:  replacement_low_ff  <= csr_write_data;
            bpr_pkg::CSR_REPLACEMENT_HIGH: replacement_high_ff <= csr_write_data;
            bpr_pkg::CSR_PATTERN_LENGTH:   pattern_length_ff   <= csr_write_data[4:0];
            bpr_pkg::CSR_REPLACE_LIMIT:    replace_limit_ff    <= csr_write_data[15:0];
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         pattern[i]       = pattern_low_ff[8*i +: 8];
         pattern[i+8]     = pattern_high_ff[8*i +: 8];
         replacement[i]   = replacement_low_ff[8*i +: 8];
         replacement[i+8] = replacement_high_ff[8*i +: 8];
      end
      pat_len = (pattern_length_ff > bpr_pkg::len_type'(MAX_PATTERN))
              ? bpr_pkg::len_type'(MAX_PATTERN) : pattern_length_ff;
   end

   assign req_ready = !pend_full;
   assign accept    = req_valid && req_ready;

   bpr_window #(.MAX_PATTERN(MAX_PATTERN)) u_window (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req           (req_data),
      .pat_len       (pat_len),
      .replace_limit (replace_limit_ff),
      .pattern       (pattern),
      .run_valid     (run_valid),
      .run           (run),
      .snap          (snap)
   );

   bpr_drain #(.MAX_PATTERN(MAX_PATTERN)) u_drain (
      .clock       (clock),
      .reset       (reset),
      .run_valid   (run_valid),
      .run         (run),
      .snap        (snap),
      .replacement (replacement),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .pend_full   (pend_full)
   );

   a_run_from_accept: assert property (@(posedge clock) disable iff (reset)
      run_valid |-> accept)
      else $error("run issued without an accepted word");

   a_run_size: assert property (@(posedge clock) disable iff (reset)
      run_valid |-> ((({1'b0, run.win_cnt} + {1'b0, run.rep_cnt}) != 6'd0) &&
                     (({1'b0, run.win_cnt} + {1'b0, run.rep_cnt}) <= 6'(MAX_PATTERN))))
      else $error("run length out of range");

   a_stall_means_busy: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with output idle");

   a_replaced_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.was_replaced) |-> (rsp_data.replace_count != 16'd0))
      else $error("replacement byte with zero replace count");

endmodule

// ===== bench/byte_pattern_replace_core_tb.sv =====
`timescale 1ns / 100ps

module byte_pattern_replace_core_tb;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   bpr_pkg::bpr_req_type   req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   bpr_pkg::bpr_rsp_type   rsp_data;
   logic                   csr_write_en = 1'b0;
   bpr_pkg::csr_index_type csr_index = bpr_pkg::CSR_PATTERN_LOW;
   bpr_pkg::csr_data_type  csr_write_data = '0;

   byte_pattern_replace_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #5 clock = ~clock;

   // shadow of the configuration and the window
   logic [63:0]       pat_lo_q, pat_hi_q, rep_lo_q, rep_hi_q;
   bpr_pkg::len_type  pat_len_q;
   bpr_pkg::cnt_type  rep_limit_q;
   bpr_pkg::byte_type win_bytes [bpr_pkg::PAT_BYTES];
   int unsigned       win_fill;
   bpr_pkg::cnt_type  repl_done;

   bpr_pkg::bpr_rsp_type pending_out [$];

   logic quiet = 1'b0;
   int   words_sent = 0;
   int   bytes_checked = 0;
   int   bytes_replaced = 0;
   int   mismatches = 0;

   function automatic int draw_wait();
      return quiet ? 0 : $urandom_range(0, 3);
   endfunction

   function automatic bpr_pkg::byte_type pop_window();
      bpr_pkg::byte_type b;
      b = win_bytes[0];
      for (int i = 1; i < bpr_pkg::PAT_BYTES; i++) win_bytes[i-1] = win_bytes[i];
      win_fill--;
      return b;
   endfunction

   function automatic void predict_patch(bpr_pkg::bpr_req_type w);
      bpr_pkg::byte_type    ob [bpr_pkg::PAT_BYTES+1];
      logic                 rb [bpr_pkg::PAT_BYTES+1];
      int unsigned          n, len;
      logic                 hit, allowed;
      logic [127:0]         pat_all, rep_all;
      bpr_pkg::bpr_rsp_type r;
      n = 0;
      pat_all = {pat_hi_q, pat_lo_q};
      rep_all = {rep_hi_q, rep_lo_q};
      len = (pat_len_q > bpr_pkg::PAT_BYTES) ? bpr_pkg::PAT_BYTES : pat_len_q;
      if (win_fill < bpr_pkg::PAT_BYTES) begin
         win_bytes[win_fill] = w.data_byte;
         win_fill++;
      end
      while (win_fill > len) begin
         ob[n] = pop_window();
         rb[n] = 1'b0;
         n++;
      end
      if (len > 0 && win_fill == len) begin
         hit = 1'b1;
         allowed = (rep_limit_q == 0) || (repl_done < rep_limit_q);
         for (int i = 0; i < len; i++)
            if (win_bytes[i] != pat_all[i*8 +: 8]) hit = 1'b0;
         if (hit && allowed) begin
            for (int i = 0; i < len; i++) begin
               ob[n] = rep_all[i*8 +: 8];
               rb[n] = 1'b1;
               n++;
            end
            win_fill = 0;
            if (repl_done != 16'hFFFF) repl_done++;
         end else begin
            ob[n] = pop_window();
            rb[n] = 1'b0;
            n++;
         end
      end
      if (w.buffer_end) begin
         while (win_fill > 0) begin
            ob[n] = pop_window();
            rb[n] = 1'b0;
            n++;
         end
      end
      for (int i = 0; i < n; i++) begin
         r.out_byte      = ob[i];
         r.was_replaced  = rb[i];
         r.run_end       = (i + 1 == n);
         r.buffer_done   = (i + 1 == n) && w.buffer_end;
         r.replace_count = repl_done;
         pending_out.push_back(r);
      end
      if (w.buffer_end) begin
         win_fill  = 0;
         repl_done = '0;
      end
   endfunction

   // result side: random stalls, compare each word with the oldest expectation
   initial begin
      int stall;
      bpr_pkg::bpr_rsp_type want;
      @(negedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid === 1'b1 && !reset)) @(posedge clock);
         if (pending_out.size() == 0) begin
            mismatches++;
            if (mismatches <= 20)
               $display("%0t: unexpected result %h", $time, rsp_data);
         end else begin
            want = pending_out.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 20)
                  $display({"%0t: mismatch expected byte %h rep %b end %b done %b cnt %0d,",
                            " got byte %h rep %b end %b done %b cnt %0d"},
                           $time, want.out_byte, want.was_replaced, want.run_end,
                           want.buffer_done, want.replace_count, rsp_data.out_byte,
                           rsp_data.was_replaced, rsp_data.run_end,
                           rsp_data.buffer_done, rsp_data.replace_count);
            end
         end
         bytes_checked++;
         if (rsp_data.was_replaced === 1'b1) bytes_replaced++;
         @(negedge clock);
      end
   end

   // entered and left at a falling edge; valid stays high after the word
   task automatic send_word(bpr_pkg::byte_type b, logic last);
      int gap;
      bpr_pkg::bpr_req_type w;
      gap = draw_wait();
      w.data_byte  = b;
      w.buffer_end = last;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      predict_patch(w);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_out.size() != 0) @(negedge clock);
      // words that fill the window only leave nothing to wait for; give them time
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(bpr_pkg::csr_index_type idx, bpr_pkg::csr_data_type value);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      case (idx)
         bpr_pkg::CSR_PATTERN_LOW:      pat_lo_q = value;
         bpr_pkg::CSR_PATTERN_HIGH:     pat_hi_q = value;
         bpr_pkg::CSR_REPLACEMENT_LOW:  rep_lo_q = value;
         bpr_pkg::CSR_REPLACEMENT_HIGH: rep_hi_q = value;
         bpr_pkg::CSR_PATTERN_LENGTH:   pat_len_q = value[4:0];
         bpr_pkg::CSR_REPLACE_LIMIT:    rep_limit_q = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_config(logic [127:0] pat, logic [127:0] rep, bpr_pkg::len_type len,
                             bpr_pkg::cnt_type limit);
      wait_idle();
      write_reg(bpr_pkg::CSR_PATTERN_LOW, pat[63:0]);
      write_reg(bpr_pkg::CSR_PATTERN_HIGH, pat[127:64]);
      write_reg(bpr_pkg::CSR_REPLACEMENT_LOW, rep[63:0]);
      write_reg(bpr_pkg::CSR_REPLACEMENT_HIGH, rep[127:64]);
      write_reg(bpr_pkg::CSR_PATTERN_LENGTH, bpr_pkg::csr_data_type'(len));
      write_reg(bpr_pkg::CSR_REPLACE_LIMIT, bpr_pkg::csr_data_type'(limit));
   endtask

   function automatic bpr_pkg::byte_type pick_symbol();
      case ($urandom_range(0, 3))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h5A;
         default: return 8'hA5;
      endcase
   endfunction

   task automatic test_pass_through();
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h5A, 1'b1);
   endtask

   task automatic test_leftmost_match();
      set_config({112'h0, 8'hB2, 8'hA1}, {$urandom, $urandom, $urandom, $urandom},
                 5'd2, 16'd0);
      send_word(8'hA1, 1'b0);
      send_word(8'hB2, 1'b0);
      send_word(8'hA1, 1'b0);
      send_word(8'hA1, 1'b0);
      send_word(8'hB2, 1'b0);
      // partial match flushed at the end
      send_word(8'hA1, 1'b1);
   endtask

   task automatic test_wide_window();
      logic [127:0] pat;
      pat = 128'hFF00_A55A_0102_0408_1020_4080_C3F0_0FFF;
      // length above the window acts as the full window
      set_config(pat, ~pat, 5'd31, 16'd0);
      for (int i = 0; i < bpr_pkg::PAT_BYTES; i++)
         send_word(pat[i*8 +: 8], i == bpr_pkg::PAT_BYTES - 1);
   endtask

   task automatic test_replace_limit();
      set_config({120'h0, 8'h7E}, {120'h0, 8'h81}, 5'd1, 16'd1);
      send_word(8'h7E, 1'b0);
      send_word(8'h7E, 1'b0);
      send_word(8'h7E, 1'b1);
   endtask

   task automatic test_length_shrink();
      set_config({96'h0, 32'h2010_0908}, {$urandom, $urandom, $urandom, $urandom},
                 5'd4, 16'd0);
      send_word(8'h01, 1'b0);
      send_word(8'h02, 1'b0);
      send_word(8'h10, 1'b0);
      wait_idle();
      write_reg(bpr_pkg::CSR_PATTERN_LOW, 64'h2010);
      write_reg(bpr_pkg::CSR_PATTERN_LENGTH, bpr_pkg::csr_data_type'(5'd2));
      send_word(8'h20, 1'b0);
      send_word(8'h55, 1'b1);
   endtask

   task automatic test_random_buffers(int phases, int words_per_phase);
      logic [127:0]      pat;
      bpr_pkg::len_type  len;
      bpr_pkg::cnt_type  limit;
      bpr_pkg::byte_type chunk [$];
      int                left, buf_len, cut;
      logic              tidy, leave_open;
      for (int p = 0; p < phases; p++) begin
         case ($urandom_range(0, 9))
            0: len = 5'd0;
            1: len = 5'd16;
            2: len = bpr_pkg::len_type'($urandom_range(6, 15));
            default: len = bpr_pkg::len_type'($urandom_range(1, 5));
         endcase
         case ($urandom_range(0, 6))
            0, 1: limit = 16'd0;
            2: limit = 16'd1;
            3: limit = 16'd2;
            4: limit = 16'hFFFF;
            default: limit = bpr_pkg::cnt_type'($urandom_range(3, 65534));
         endcase
         for (int i = 0; i < bpr_pkg::PAT_BYTES; i++)
            pat[i*8 +: 8] = (i < len) ? pick_symbol()
                                      : bpr_pkg::byte_type'($urandom_range(0, 255));
         set_config(pat, {$urandom, $urandom, $urandom, $urandom}, len, limit);
         quiet = ($urandom_range(0, 3) == 0);
         left = words_per_phase;
         while (left > 0) begin
            buf_len = $urandom_range(1, 20);
            tidy = ($urandom_range(0, 9) < 7);
            chunk.delete();
            while (chunk.size() < buf_len) begin
               if (tidy && len > 0 && $urandom_range(0, 1)) begin
                  cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : len;
                  for (int i = 0; i < cut; i++) chunk.push_back(pat[i*8 +: 8]);
               end else if (tidy) begin
                  chunk.push_back(pick_symbol());
               end else begin
                  chunk.push_back(bpr_pkg::byte_type'($urandom_range(0, 255)));
               end
            end
            left -= chunk.size();
            leave_open = (left <= 0) && ($urandom_range(0, 2) == 0);
            for (int i = 0; i < chunk.size(); i++)
               send_word(chunk[i], (i == chunk.size() - 1) && !leave_open);
            // drain the output with the input held off
            if ($urandom_range(0, 9) == 0) begin
               req_valid <= 1'b0;
               while (pending_out.size() != 0) @(negedge clock);
            end
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      pat_lo_q    = '0;
      pat_hi_q    = '0;
      rep_lo_q    = '0;
      rep_hi_q    = '0;
      pat_len_q   = '0;
      rep_limit_q = '0;
      win_fill    = 0;
      repl_done   = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_pass_through();
      test_leftmost_match();
      test_wide_window();
      test_replace_limit();
      test_length_shrink();
      test_random_buffers(8, 43);

      wait_idle();
      repeat (20) @(negedge clock);
      $display("Sent %0d words; checked %0d output bytes, %0d of them replaced.",
               words_sent, bytes_checked, bytes_replaced);
      $display({"Covered pass-through, leftmost matches, full window, limits,",
                " length change and random buffers; %0d mismatches."},
               mismatches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout at %0t with %0d results outstanding", $time, pending_out.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
